// ===== hdl/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg: station packet filter shared definitions
// Transaction payload types, station entry layout, action, type, verdict and register index codes.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int unsigned STATIONS_DEF       = 256;
  localparam logic [31:0] INITIAL_HANDLE_DEF = 32'h0000_1000;
  localparam logic [15:0] HEADER_BYTES       = 16'd8;

  localparam logic [31:0] LOOPBACK_ADDR = 32'h7f00_0001;
  localparam logic [15:0] BCAST_STATION = 16'hffff;
  localparam logic [31:0] HANDLE_STEP   = 32'd4;

  // input action codes
  localparam logic [1:0] ACT_RX   = 2'd0;
  localparam logic [1:0] ACT_TX   = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // header type codes
  localparam logic [7:0] TYPE_BCAST     = 8'd1;
  localparam logic [7:0] TYPE_UNICAST   = 8'd2;
  localparam logic [7:0] TYPE_ACK       = 8'd3;
  localparam logic [7:0] TYPE_IMM       = 8'd5;
  localparam logic [7:0] TYPE_IMM_REPLY = 8'd6;

  // verdict codes
  localparam logic [3:0] V_SHORT      = 4'd0;
  localparam logic [3:0] V_RANGE      = 4'd1;
  localparam logic [3:0] V_OWN        = 4'd2;
  localparam logic [3:0] V_ADDR       = 4'd3;
  localparam logic [3:0] V_DUP        = 4'd4;
  localparam logic [3:0] V_BCAST      = 4'd5;
  localparam logic [3:0] V_QUEUED     = 4'd6;
  localparam logic [3:0] V_QUEUE_FULL = 4'd7;
  localparam logic [3:0] V_ACK        = 4'd8;
  localparam logic [3:0] V_REPLY      = 4'd9;
  localparam logic [3:0] V_UNKNOWN    = 4'd10;
  localparam logic [3:0] V_TX_SENT    = 4'd11;
  localparam logic [3:0] V_TX_BCAST   = 4'd12;
  localparam logic [3:0] V_TX_RANGE   = 4'd13;
  localparam logic [3:0] V_TICK       = 4'd14;

  // configuration register indexes
  localparam logic [1:0] CFG_MY_STATION     = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd1;
  localparam logic [1:0] CFG_OPTIMISTIC_ACK = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] station;
    logic [31:0] source_addr;
    logic [7:0]  packet_type;
    logic [31:0] handle;
    logic [15:0] datagram_length;
    logic [7:0]  port_byte;
    logic [7:0]  control;
    logic        queue_ready;
  } in_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic        deliver;
    logic        send_ack;
    logic        disable_receiver;
    logic        new_station;
    logic [7:0]  tx_type;
    logic [7:0]  tx_port;
    logic [6:0]  tx_control;
    logic [31:0] tx_handle;
    logic [31:0] tx_address;
  } out_t;

  typedef struct packed {
    logic [31:0] peer_address;
    logic [31:0] last_rx_handle;
    logic [31:0] rx_deadline;
    logic [31:0] next_tx_handle;
  } entry_t;

endpackage

// ===== hdl/station_packet_filter_top.sv =====
// ----------------------------------------------------------------------------
// station_packet_filter_top: per-station receive filter and transmit header
// Checks received headers against the station table, builds transmit headers.
// ----------------------------------------------------------------------------
// Latency: a result passes through the stage 1 register and then the result register.
// Throughput: one transaction per cycle while out_stall is low; the station
//   entry read-modify-write spans the table read register and the result register.
// Reset: synchronous, active low. After reset the table is swept to zero,
//   one entry per cycle, over all STATIONS entries; in_stall is high meanwhile.
// ----------------------------------------------------------------------------
module station_packet_filter_top #(
  parameter int unsigned STATIONS       = spf_pkg::STATIONS_DEF,
  parameter logic [31:0] INITIAL_HANDLE = spf_pkg::INITIAL_HANDLE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  spf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output spf_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);

  localparam int unsigned IW = $clog2(STATIONS);
  localparam logic [16:0] STATIONS_LIM = 17'(STATIONS);
  localparam logic [IW-1:0] LAST_IDX = IW'(STATIONS - 1);

  // configuration registers
  logic [15:0] my_station_r;
  logic [31:0] timeout_ticks_r;
  logic        optimistic_ack_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_station_r     <= '0;
      timeout_ticks_r  <= '0;
      optimistic_ack_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spf_pkg::CFG_MY_STATION:     my_station_r     <= cfg_wdata[15:0];
        spf_pkg::CFG_TIMEOUT_TICKS:  timeout_ticks_r  <= cfg_wdata;
        spf_pkg::CFG_OPTIMISTIC_ACK: optimistic_ack_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // post-reset clearing sweep over the station table
  logic          clr_busy_r;
  logic [IW-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == LAST_IDX) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  // handshake and pipeline control
  logic          s1_v_r;
  spf_pkg::in_t  s1_r;
  logic          out_v_r;
  spf_pkg::out_t out_r;
  logic          advance;
  logic          accept;

  // stage 1 moves into the result register when that register is free or draining
  assign advance  = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = clr_busy_r || (s1_v_r && !advance);
  assign accept   = in_valid && !in_stall;

  // station table: read issued with the accepted transaction, data lands with stage 1
  spf_pkg::entry_t ent;
  spf_pkg::entry_t wr_entry;
  logic            wr_req;
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  spf_pkg::entry_t ram_wdata;

  assign ram_we    = clr_busy_r || (advance && wr_req);
  assign ram_waddr = clr_busy_r ? clr_idx_r : s1_r.station[IW-1:0];
  assign ram_wdata = clr_busy_r ? '0 : wr_entry;

  spf_station_ram #(
    .STATIONS (STATIONS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (accept),
    .rd_addr (in_data.station[IW-1:0]),
    .rd_data (ent)
  );

  // tick counter, advanced when a tick transaction leaves stage 1
  logic [31:0] tick_count_r;
  logic [31:0] tick_count_nxt;

  // per-transaction decision logic
  logic          in_range;
  logic          empty_entry;
  logic          fresh;
  logic [31:0]   deadline_new;
  logic [31:0]   tx_base;
  logic [31:0]   tx_handle_new;
  spf_pkg::out_t res;

  assign in_range      = {1'b0, s1_r.station} < STATIONS_LIM;
  assign empty_entry   = (ent.peer_address == 32'd0);
  // newer handle, or the duplicate window has run out
  assign fresh         = (s1_r.handle > ent.last_rx_handle) ||
                         (tick_count_r > ent.rx_deadline);
  assign deadline_new  = tick_count_r + timeout_ticks_r;
  assign tx_base       = empty_entry ? INITIAL_HANDLE : ent.next_tx_handle;
  assign tx_handle_new = tx_base + spf_pkg::HANDLE_STEP;

  always_comb begin
    res            = '0;
    wr_req         = 1'b0;
    wr_entry       = ent;
    tick_count_nxt = tick_count_r;
    unique case (s1_r.action)
      spf_pkg::ACT_RX: begin
        if (s1_r.datagram_length < spf_pkg::HEADER_BYTES) begin
          res.verdict = spf_pkg::V_SHORT;
        end else if (!in_range) begin
          res.verdict = spf_pkg::V_RANGE;
        end else if (s1_r.station == my_station_r) begin
          res.verdict = spf_pkg::V_OWN;
        end else begin
          // the entry is written back from here on, learned address included
          wr_req = 1'b1;
          if (empty_entry) begin
            wr_entry.peer_address   = s1_r.source_addr;
            wr_entry.next_tx_handle = INITIAL_HANDLE;
            res.new_station         = 1'b1;
          end
          if (!empty_entry && (ent.peer_address != s1_r.source_addr)) begin
            res.verdict = spf_pkg::V_ADDR;
          end else if (!fresh) begin
            res.verdict = spf_pkg::V_DUP;
          end else begin
            case (s1_r.packet_type) inside
              spf_pkg::TYPE_BCAST: begin
                res.verdict = spf_pkg::V_BCAST;
              end
              spf_pkg::TYPE_UNICAST, spf_pkg::TYPE_IMM: begin
                // handle and window advance even when the queue is full
                wr_entry.last_rx_handle = s1_r.handle;
                wr_entry.rx_deadline    = deadline_new;
                if (s1_r.queue_ready) begin
                  res.verdict  = spf_pkg::V_QUEUED;
                  res.deliver  = 1'b1;
                  res.send_ack = optimistic_ack_r;
                end else begin
                  res.verdict = spf_pkg::V_QUEUE_FULL;
                end
              end
              spf_pkg::TYPE_ACK: begin
                res.verdict          = spf_pkg::V_ACK;
                res.disable_receiver = 1'b1;
              end
              spf_pkg::TYPE_IMM_REPLY: begin
                res.verdict          = spf_pkg::V_REPLY;
                res.disable_receiver = 1'b1;
              end
              default: begin
                res.verdict = spf_pkg::V_UNKNOWN;
              end
            endcase
          end
        end
      end
      spf_pkg::ACT_TX: begin
        if (s1_r.station == spf_pkg::BCAST_STATION) begin
          res.verdict = spf_pkg::V_TX_BCAST;
        end else if (!in_range) begin
          res.verdict = spf_pkg::V_TX_RANGE;
        end else begin
          wr_req = 1'b1;
          if (empty_entry) begin
            wr_entry.peer_address = spf_pkg::LOOPBACK_ADDR;
            res.new_station       = 1'b1;
          end
          wr_entry.next_tx_handle = tx_handle_new;
          res.verdict    = spf_pkg::V_TX_SENT;
          res.tx_type    = (s1_r.port_byte == 8'd0) ? spf_pkg::TYPE_IMM
                                                    : spf_pkg::TYPE_UNICAST;
          res.tx_port    = s1_r.port_byte;
          res.tx_control = s1_r.control[6:0];
          res.tx_handle  = tx_handle_new;
          res.tx_address = wr_entry.peer_address;
        end
      end
      spf_pkg::ACT_TICK: begin
        tick_count_nxt = tick_count_r + 32'd1;
        res.verdict    = spf_pkg::V_TICK;
      end
      default: begin
        // unused action: no state change
        res.verdict = spf_pkg::V_TICK;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      tick_count_r <= '0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r      <= 1'b1;
        tick_count_r <= tick_count_nxt;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/spf_station_ram.sv =====
// ----------------------------------------------------------------------------
// spf_station_ram: station entry memory
// One write port, one registered read port with write-to-read bypass.
// ----------------------------------------------------------------------------
module spf_station_ram #(
  parameter int unsigned STATIONS = spf_pkg::STATIONS_DEF
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(STATIONS)-1:0] wr_addr,
  input  spf_pkg::entry_t             wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(STATIONS)-1:0] rd_addr,
  output spf_pkg::entry_t             rd_data
);

  spf_pkg::entry_t mem [STATIONS];
  spf_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a read in the same cycle as a write to that entry returns the new data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/spf_checker.sv =====
// ----------------------------------------------------------------------------
// spf_checker: port-level checks for the station packet filter
// Watches the transaction ports of the top level over time.
// ----------------------------------------------------------------------------
module spf_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input spf_pkg::out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the table sweep keeps the input side stalled right after reset
  a_sweep_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during table sweep");

  // delivery only with a queued verdict
  a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.deliver |-> out_data.verdict == spf_pkg::V_QUEUED)
    else $error("deliver without queued verdict");

  // transmit fields are only filled for a sent header
  a_tx_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict != spf_pkg::V_TX_SENT |->
      out_data.tx_type == 8'd0 && out_data.tx_handle == 32'd0 &&
      out_data.tx_address == 32'd0)
    else $error("transmit fields set on a non-transmit result");

endmodule

bind station_packet_filter_top spf_checker u_spf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== dv/station_packet_filter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// station_packet_filter_checker: result predictor and comparator
// Watches both channels and the register port, keeps its own station table,
// predicts one result per input transaction and compares it with the block.
// ----------------------------------------------------------------------------
module station_packet_filter_checker #(
  parameter int unsigned STATIONS       = spf_pkg::STATIONS_DEF,
  parameter logic [31:0] INITIAL_HANDLE = spf_pkg::INITIAL_HANDLE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  spf_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  spf_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_wdata,
  output int            mismatches,
  output int            outstanding
);

  localparam int unsigned IW = $clog2(STATIONS);

  logic [31:0] peer_addr_tbl   [STATIONS];
  logic [31:0] rx_handle_tbl   [STATIONS];
  logic [31:0] rx_deadline_tbl [STATIONS];
  logic [31:0] tx_handle_tbl   [STATIONS];
  logic [31:0] tick_ctr;

  logic [15:0] own_station;
  logic [31:0] window_len;
  logic        early_ack;

  spf_pkg::out_t awaited_verdicts [$];
  spf_pkg::out_t oldest;

  // Advances the station table by one input transaction, returns its result.
  function automatic spf_pkg::out_t filter_verdict(spf_pkg::in_t t);
    spf_pkg::out_t r;
    logic [15:0]   s;
    logic [IW-1:0] k;
    r = '0;
    s = t.station;
    k = s[IW-1:0];
    case (t.action)
      spf_pkg::ACT_RX: begin
        if (t.datagram_length < spf_pkg::HEADER_BYTES) begin
          r.verdict = spf_pkg::V_SHORT;
        end else if (s >= STATIONS) begin
          r.verdict = spf_pkg::V_RANGE;
        end else if (s == own_station) begin
          r.verdict = spf_pkg::V_OWN;
        end else begin
          if (peer_addr_tbl[k] == '0) begin
            peer_addr_tbl[k] = t.source_addr;
            tx_handle_tbl[k] = INITIAL_HANDLE;
            r.new_station = 1'b1;
          end
          if (peer_addr_tbl[k] != t.source_addr) begin
            r.verdict = spf_pkg::V_ADDR;
          end else if (!(t.handle > rx_handle_tbl[k] ||
                         tick_ctr > rx_deadline_tbl[k])) begin
            r.verdict = spf_pkg::V_DUP;
          end else begin
            case (t.packet_type) inside
              spf_pkg::TYPE_BCAST: r.verdict = spf_pkg::V_BCAST;
              spf_pkg::TYPE_UNICAST, spf_pkg::TYPE_IMM: begin
                rx_handle_tbl[k] = t.handle;
                rx_deadline_tbl[k] = tick_ctr + window_len;
                if (t.queue_ready) begin
                  r.verdict = spf_pkg::V_QUEUED;
                  r.deliver = 1'b1;
                  r.send_ack = early_ack;
                end else begin
                  r.verdict = spf_pkg::V_QUEUE_FULL;
                end
              end
              spf_pkg::TYPE_ACK: begin
                r.verdict = spf_pkg::V_ACK;
                r.disable_receiver = 1'b1;
              end
              spf_pkg::TYPE_IMM_REPLY: begin
                r.verdict = spf_pkg::V_REPLY;
                r.disable_receiver = 1'b1;
              end
              default: r.verdict = spf_pkg::V_UNKNOWN;
            endcase
          end
        end
      end
      spf_pkg::ACT_TX: begin
        if (s == spf_pkg::BCAST_STATION) begin
          r.verdict = spf_pkg::V_TX_BCAST;
        end else if (s >= STATIONS) begin
          r.verdict = spf_pkg::V_TX_RANGE;
        end else begin
          if (peer_addr_tbl[k] == '0) begin
            peer_addr_tbl[k] = spf_pkg::LOOPBACK_ADDR;
            tx_handle_tbl[k] = INITIAL_HANDLE;
            r.new_station = 1'b1;
          end
          tx_handle_tbl[k] = tx_handle_tbl[k] + spf_pkg::HANDLE_STEP;
          r.verdict = spf_pkg::V_TX_SENT;
          r.tx_type = (t.port_byte == '0) ? spf_pkg::TYPE_IMM : spf_pkg::TYPE_UNICAST;
          r.tx_port = t.port_byte;
          r.tx_control = t.control[6:0];
          r.tx_handle = tx_handle_tbl[k];
          r.tx_address = peer_addr_tbl[k];
        end
      end
      spf_pkg::ACT_TICK: begin
        tick_ctr = tick_ctr + 32'd1;
        r.verdict = spf_pkg::V_TICK;
      end
      default: r.verdict = spf_pkg::V_TICK;
    endcase
    return r;
  endfunction

  function automatic string show(spf_pkg::out_t r);
    return $sformatf({"v=%0d dlv=%b ack=%b dis=%b new=%b ",
                      "type=%h port=%h ctl=%h hdl=%h addr=%h"},
                     r.verdict, r.deliver, r.send_ack, r.disable_receiver, r.new_station,
                     r.tx_type, r.tx_port, r.tx_control, r.tx_handle, r.tx_address);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      peer_addr_tbl = '{default: '0};
      rx_handle_tbl = '{default: '0};
      rx_deadline_tbl = '{default: '0};
      tx_handle_tbl = '{default: '0};
      tick_ctr = '0;
      own_station = '0;
      window_len = '0;
      early_ack = 1'b0;
      awaited_verdicts.delete();
      mismatches = 0;
      outstanding = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          spf_pkg::CFG_MY_STATION:     own_station = cfg_wdata[15:0];
          spf_pkg::CFG_TIMEOUT_TICKS:  window_len = cfg_wdata;
          spf_pkg::CFG_OPTIMISTIC_ACK: early_ack = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (awaited_verdicts.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result: %s", show(out_data));
        end else begin
          oldest = awaited_verdicts.pop_front();
          if (out_data !== oldest) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("result mismatch\n  expected %s\n  actual   %s",
                       show(oldest), show(out_data));
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_verdicts.push_back(filter_verdict(in_data));
      outstanding = awaited_verdicts.size();
    end
  end

endmodule

// ===== dv/station_packet_filter_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// station_packet_filter_top_test: station packet filter testbench
// Directed headers, transmit requests and ticks, then random traffic over
// several register settings; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module station_packet_filter_top_test;

  localparam int unsigned NSTN        = spf_pkg::STATIONS_DEF;
  localparam int unsigned IW          = $clog2(NSTN);
  localparam int          QUIET_LIMIT = 3000;  // covers the table sweep and hold-offs
  localparam int          PHASE_ITEMS = 150;
  localparam int          HOLD_CYCLES = 80;

  localparam logic [1:0]  ACT_UNUSED  = 2'd3;  // the spare action code
  localparam logic [7:0]  TYPE_NACK   = 8'd4;  // no meaning to the filter
  localparam logic [31:0] STATION_NET = 32'h0a01_0000;
  localparam logic [31:0] ADDR_A      = 32'h0a01_0001;
  localparam logic [31:0] ADDR_B      = 32'hc0a8_0101;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  spf_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  spf_pkg::out_t out_data;
  logic          cfg_we;
  logic [1:0]    cfg_index;
  logic [31:0]   cfg_wdata;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;

  // Stimulus-side notes, only used to shape traffic into well-formed
  // sequences: the address each station answers to and its newest rx handle.
  logic [31:0] addr_hint [NSTN];
  logic [31:0] rx_seq    [NSTN];
  logic [15:0] own_stn;
  int          burst_left;
  bit          squeeze;

  always #6 clk = ~clk;

  station_packet_filter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  station_packet_filter_checker checker_u (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Watchdog: a quiet stretch that runs up to QUIET_LIMIT with no transaction on
  // either channel means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("station_packet_filter_top_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: segments of free flow, light and heavy stalling. When asked,
  // it holds off for a long stretch so the block backs up into in_stall.
  initial begin : receiver
    int seg;
    int mode;
    out_stall = 1'b0;
    forever begin
      if (squeeze) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        squeeze = 1'b0;
      end else begin
        mode = $urandom_range(0, 2);
        seg = $urandom_range(10, 60);
        repeat (seg) begin
          @(negedge clk);
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 9) < 7);
          endcase
        end
      end
    end
  end

  // All fields random; builders below overwrite what the action uses.
  function automatic spf_pkg::in_t noise_item();
    spf_pkg::in_t t;
    t.action          = 2'($urandom_range(0, 3));
    t.station         = 16'($urandom);
    t.source_addr     = $urandom;
    t.packet_type     = 8'($urandom);
    t.handle          = $urandom;
    t.datagram_length = 16'($urandom);
    t.port_byte       = 8'($urandom);
    t.control         = 8'($urandom);
    t.queue_ready     = 1'($urandom);
    return t;
  endfunction

  function automatic spf_pkg::in_t beat_item(logic [1:0] act);
    spf_pkg::in_t t;
    t = noise_item();
    t.action = act;
    return t;
  endfunction

  function automatic spf_pkg::in_t rx_item(logic [15:0] stn, logic [31:0] addr,
                                           logic [31:0] hdl, logic [7:0] ptype,
                                           logic [15:0] len, bit ready);
    spf_pkg::in_t t;
    t = noise_item();
    t.action          = spf_pkg::ACT_RX;
    t.station         = stn;
    t.source_addr     = addr;
    t.handle          = hdl;
    t.packet_type     = ptype;
    t.datagram_length = len;
    t.queue_ready     = ready;
    return t;
  endfunction

  function automatic spf_pkg::in_t tx_item(logic [15:0] stn, logic [7:0] port,
                                           logic [7:0] ctl);
    spf_pkg::in_t t;
    t = noise_item();
    t.action    = spf_pkg::ACT_TX;
    t.station   = stn;
    t.port_byte = port;
    t.control   = ctl;
    return t;
  endfunction

  // Mostly well-formed traffic to a small set of stations with fresh handles,
  // the rest broken headers (short, wrong sender, stale handle, own station).
  function automatic spf_pkg::in_t random_item();
    spf_pkg::in_t  t;
    logic [15:0]   s;
    logic [IW-1:0] k;
    logic [31:0]   a;
    logic [31:0]   base;
    logic [7:0]    ptype;
    bit            known;
    int            pick;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 19))
      0:          s = 16'($urandom);
      1:          s = spf_pkg::BCAST_STATION;
      2, 3, 4, 5: s = 16'($urandom_range(0, NSTN - 1));
      default:    s = 16'($urandom_range(0, 15));
    endcase
    known = (s < NSTN);
    k = s[IW-1:0];
    if (pick < 8)
      return beat_item(spf_pkg::ACT_TICK);
    if (pick < 9)
      return beat_item(ACT_UNUSED);
    if (pick < 33)
      return tx_item(s, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom), 8'($urandom));
    a = known ? addr_hint[k] : $urandom;
    // an unlearned station now and then sees a zero sender address
    if (a == '0 && $urandom_range(0, 9) != 0)
      a = STATION_NET | 32'(s);
    base = known ? rx_seq[k] : $urandom;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: ptype = spf_pkg::TYPE_UNICAST;
      4, 5:       ptype = spf_pkg::TYPE_IMM;
      6:          ptype = spf_pkg::TYPE_BCAST;
      7:          ptype = spf_pkg::TYPE_ACK;
      8:          ptype = spf_pkg::TYPE_IMM_REPLY;
      9:          ptype = TYPE_NACK;
      default:    ptype = 8'($urandom);
    endcase
    t = rx_item(s, a, base + 32'($urandom_range(1, 3)), ptype,
                16'($urandom_range(8, 65535)), $urandom_range(0, 3) != 0);
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 4))
        0:       t.datagram_length = 16'($urandom_range(0, 7));
        1:       t.source_addr = $urandom;
        2:       t.handle = base;
        3:       t.handle = base - 32'($urandom_range(1, 100));
        default: t.station = own_stn;
      endcase
    end
    return t;
  endfunction

  // Offers one transaction and waits for it to be taken. Bursts of random
  // length, with random gaps (sometimes none) between them.
  task automatic offer(spf_pkg::in_t item);
    logic [IW-1:0] k;
    k = item.station[IW-1:0];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
    burst_left = burst_left - 1;
    // keep the stimulus notes in step, in issue order
    if (item.action == spf_pkg::ACT_RX && item.station < NSTN) begin
      if (item.datagram_length >= spf_pkg::HEADER_BYTES && item.station != own_stn &&
          addr_hint[k] == '0)
        addr_hint[k] = item.source_addr;
      if (item.handle > rx_seq[k])
        rx_seq[k] = item.handle;
    end
    if (item.action == spf_pkg::ACT_TX && item.station < NSTN && addr_hint[k] == '0)
      addr_hint[k] = spf_pkg::LOOPBACK_ADDR;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Drops valid and waits for every outstanding result.
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  // Writes all three registers; upper write-data bits carry junk in the station and acknowledge writes.
  task automatic load_registers(logic [15:0] stn, logic [31:0] win, logic early);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= spf_pkg::CFG_MY_STATION;
    cfg_wdata <= {16'($urandom), stn};
    @(negedge clk);
    cfg_index <= spf_pkg::CFG_TIMEOUT_TICKS;
    cfg_wdata <= win;
    @(negedge clk);
    cfg_index <= spf_pkg::CFG_OPTIMISTIC_ACK;
    cfg_wdata <= {31'($urandom), early};
    @(negedge clk) cfg_we <= 1'b0;
    own_stn = stn;
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = spf_pkg::CFG_MY_STATION;
    cfg_wdata = '0;
    own_stn = '0;
    burst_left = 0;
    squeeze = 1'b0;
    for (int i = 0; i < NSTN; i++) begin
      addr_hint[i] = '0;
      // low stations count up from zero, the rest start anywhere
      rx_seq[i] = (i < 16) ? 32'd0 : $urandom;
    end
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: own station 7, window of 4 ticks, early acknowledge on.
    load_registers(16'd7, 32'd4, 1'b1);
    // short, first bad station, own station
    offer(rx_item(16'd1, ADDR_A, 32'd10, spf_pkg::TYPE_UNICAST, 16'd7, 1'b1));
    offer(rx_item(16'd256, ADDR_A, 32'd10, spf_pkg::TYPE_UNICAST, 16'd8, 1'b1));
    offer(rx_item(16'd7, ADDR_A, 32'd10, spf_pkg::TYPE_UNICAST, 16'hffff, 1'b1));
    // learn and queue, wrong sender, duplicate, queue full
    offer(rx_item(16'd1, ADDR_A, 32'd10, spf_pkg::TYPE_UNICAST, 16'd64, 1'b1));
    offer(rx_item(16'd1, ADDR_B, 32'd11, spf_pkg::TYPE_UNICAST, 16'd64, 1'b1));
    offer(rx_item(16'd1, ADDR_A, 32'd10, spf_pkg::TYPE_UNICAST, 16'd64, 1'b1));
    offer(rx_item(16'd1, ADDR_A, 32'd11, spf_pkg::TYPE_IMM, 16'd64, 1'b0));
    offer(rx_item(16'd1, ADDR_A, 32'd12, spf_pkg::TYPE_BCAST, 16'd64, 1'b1));
    offer(rx_item(16'd1, ADDR_A, 32'd13, spf_pkg::TYPE_ACK, 16'd64, 1'b1));
    offer(rx_item(16'd1, ADDR_A, 32'd14, spf_pkg::TYPE_IMM_REPLY, 16'd64, 1'b1));
    offer(rx_item(16'd1, ADDR_A, 32'd15, 8'hff, 16'd64, 1'b1));  // unknown type
    // zero sender, twice: the entry stays empty
    offer(rx_item(16'd2, 32'd0, 32'd1, spf_pkg::TYPE_UNICAST, 16'd64, 1'b1));
    offer(rx_item(16'd2, 32'd0, 32'd1, spf_pkg::TYPE_UNICAST, 16'd64, 1'b1));
    offer(tx_item(16'd1, 8'h00, 8'hff));                 // immediate
    offer(tx_item(16'd3, 8'hff, 8'h80));                 // loopback default
    offer(tx_item(spf_pkg::BCAST_STATION, 8'h12, 8'h34));
    offer(tx_item(16'd256, 8'h12, 8'h34));
    offer(tx_item(16'd7, 8'h01, 8'h7f));                 // own, not checked
    offer(beat_item(spf_pkg::ACT_TICK));
    offer(beat_item(ACT_UNUSED));
    // inside the window, then after it has run out
    offer(rx_item(16'd1, ADDR_A, 32'd11, spf_pkg::TYPE_UNICAST, 16'd64, 1'b1));
    repeat (4) offer(beat_item(spf_pkg::ACT_TICK));
    offer(rx_item(16'd1, ADDR_A, 32'd11, spf_pkg::TYPE_UNICAST, 16'd64, 1'b1));
    offer(rx_item(16'd1, ADDR_A, 32'hffff_ffff, spf_pkg::TYPE_UNICAST, 16'd64, 1'b1));
    settle();

    // Random phases over a spread of settings, extremes included.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_registers(16'h0000, 32'h0000_0000, 1'b0);
        1: load_registers(16'hffff, 32'hffff_ffff, 1'b1);
        2: load_registers(16'd3, 32'd2, 1'b1);
        3: load_registers(16'($urandom_range(0, 15)), 32'($urandom_range(1, 40)),
                          1'($urandom));
        4: load_registers(16'($urandom), $urandom, 1'b0);
        default: load_registers(16'd200, 32'd10, 1'($urandom));
      endcase
      // one long receiver hold-off while traffic keeps coming
      if (p == 2)
        squeeze = 1'b1;
      repeat (PHASE_ITEMS) offer(random_item());
      settle();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("station_packet_filter_top_test OK");
    end else begin
      $display("station_packet_filter_top_test NOT OK");
    end
    $finish;
  end

endmodule
